>>> sv/rwmr_pkg.sv
// Shared types and constants for the relay controller with on-time watchdog
// and auto-restart delay. No dependencies; imported by rwmr_step and the core.
package rwmr_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int CNT_W    = 26;
	localparam int SEC_W    = 16;
	localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
	localparam int PROD_W   = SEC_W + TPS_W;
	localparam int WIDE_W   = (PROD_W > CNT_W) ? PROD_W : CNT_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_SET   = 2'd1,
		ACT_FORCE = 2'd2,
		ACT_INIT  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_SECONDS  = 2'd0,
		REG_MAX_ON_SECONDS = 2'd1,
		REG_BOOT_ON        = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		action_t action;
		logic    switch_on;
		logic    manual;
	} item_t;

	typedef struct packed {
		logic             relay;
		logic             armed;
		logic             emerg;
		logic [CNT_W-1:0] on_elapsed;
		logic [CNT_W-1:0] delay_left;
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]  delay_load;
		logic [WIDE_W-1:0] max_on_ticks;
		logic              boot_on;
	} cfg_t;

	typedef struct packed {
		logic relay_on;
		logic delay_running;
		logic emergency_stopped;
		logic switched;
		logic manual_event;
		logic force_stop_event;
	} result_t;

endpackage

>>> sv/rwmr_step.sv
// Next-state and result logic for one item of the relay controller.
// Depends on rwmr_pkg for the item, state, configuration and result types.
module rwmr_step (
	input  rwmr_pkg::state_t  cur,
	input  rwmr_pkg::item_t   item,
	input  rwmr_pkg::cfg_t    cfg,
	output rwmr_pkg::state_t  nxt,
	output rwmr_pkg::result_t res
);
	import rwmr_pkg::*;

	always_comb begin
		state_t s;
		logic   ev_sw;
		logic   ev_man;
		logic   ev_force;
		logic   expired;
		s        = cur;
		ev_sw    = 1'b0;
		ev_man   = 1'b0;
		ev_force = 1'b0;
		expired  = 1'b0;
		unique case (item.action)
			ACT_TICK: begin
				if (s.relay) begin
					if (s.on_elapsed != CNT_MAX) s.on_elapsed = s.on_elapsed + CNT_W'(1);
					if (cfg.max_on_ticks != '0 &&
					    WIDE_W'(s.on_elapsed) > cfg.max_on_ticks) begin
						ev_man       = 1'b1;
						s.armed      = 1'b0;
						s.relay      = 1'b0;
						ev_sw        = 1'b1;
						s.on_elapsed = '0;
						s.emerg      = 1'b1;
						ev_force     = 1'b1;
					end
				end
				if (s.armed) begin
					if (s.delay_left != '0) s.delay_left = s.delay_left - CNT_W'(1);
					if (s.delay_left == '0) begin
						s.armed = 1'b0;
						expired = 1'b1;
					end
				end
				if (expired && !s.relay) begin
					ev_man       = 1'b1;
					s.relay      = 1'b1;
					ev_sw        = 1'b1;
					s.emerg      = 1'b0;
					s.on_elapsed = '0;
				end
				if (!s.relay && !s.armed && cfg.delay_load != '0) begin
					s.armed      = 1'b1;
					s.delay_left = cfg.delay_load;
				end
			end
			ACT_SET: begin
				if (item.manual) begin
					ev_man  = 1'b1;
					s.armed = 1'b0;
				end
				if (s.relay != item.switch_on) begin
					s.relay      = item.switch_on;
					ev_sw        = 1'b1;
					if (item.switch_on) s.emerg = 1'b0;
					s.on_elapsed = '0;
				end
			end
			ACT_FORCE: begin
				ev_man  = 1'b1;
				s.armed = 1'b0;
				if (s.relay) begin
					s.relay      = 1'b0;
					ev_sw        = 1'b1;
					s.on_elapsed = '0;
				end
				s.emerg  = 1'b1;
				ev_force = 1'b1;
			end
			ACT_INIT: begin
				s.armed      = 1'b0;
				s.delay_left = '0;
				s.emerg      = 1'b0;
				s.on_elapsed = '0;
				s.relay      = cfg.boot_on;
				ev_sw        = 1'b1;
			end
			default: begin
				s = cur;
			end
		endcase
		nxt                   = s;
		res.relay_on          = s.relay;
		res.delay_running     = s.armed;
		res.emergency_stopped = s.emerg;
		res.switched          = ev_sw;
		res.manual_event      = ev_man;
		res.force_stop_event  = ev_force;
	end

endmodule

>>> sv/relay_with_max_on_and_restart_delay_core.sv
// Top level of the relay controller: configuration registers, controller state,
// output register and stream handshakes. Depends on rwmr_pkg and rwmr_step.
//
// Usage:
//   Slave stream (s_*) carries one action item per handshake: tick, set,
//   force stop or init. Master stream (m_*) returns exactly one status item
//   per accepted action, in order.
//   The configuration channel (cfg_*) writes delay_seconds (index 0),
//   max_on_seconds (index 1) and boot_on (index 2); other indexes are ignored.
//   cfg_ready is always high; each second count is scaled to ticks once, at
//   the write, so the item path holds only counter updates and compares.
// Output: a result appears on m_tvalid in the cycle after its item is accepted.
// Throughput: one item per cycle while the output register is not stalled by m_tready.
// Stall: the output register holds its item while m_tready is low; s_tready
//   stays high as long as the output register is empty or is being drained
//   in the same cycle.
// Reset: arst_n clears the relay state, delay, emergency flag, counters,
//   configuration and the output valid flag at once.
module relay_with_max_on_and_restart_delay_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // action[1:0], switch_on, manual, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // relay_on, delay_running,
	                                                 // emergency_stopped, switched,
	                                                 // manual_event, force_stop_event, zero pad
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rwmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import rwmr_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    in_acc;
	logic [WIDE_W-1:0] prod;
	logic [CNT_W-1:0]  prod_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;

	assign item.action    = action_t'(s_tdata[1:0]);
	assign item.switch_on = s_tdata[2];
	assign item.manual    = s_tdata[3];

	assign prod     = WIDE_W'(cfg_data) * WIDE_W'(TICKS_PER_SECOND);
	assign prod_sat = (prod > WIDE_W'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];

	rwmr_step u_step (
		.cur  (state_q),
		.item (item),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DELAY_SECONDS:  cfg_q.delay_load   <= prod_sat;
				REG_MAX_ON_SECONDS: cfg_q.max_on_ticks <= prod;
				REG_BOOT_ON:        cfg_q.boot_on      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.force_stop_event, res_q.manual_event, res_q.switched,
	                   res_q.emergency_stopped, res_q.delay_running, res_q.relay_on};

endmodule

>>> dv/relay_with_max_on_and_restart_delay_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for relay_with_max_on_and_restart_delay_core: drives action items
// with random gaps and output stalls, predicts each status item in-line and compares.
// Depends on rwmr_pkg and the core RTL.
module relay_with_max_on_and_restart_delay_core_tb;
	import rwmr_pkg::*;

	localparam int LIMIT = 500000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	relay_with_max_on_and_restart_delay_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [7:0] action_q[$];
	logic [5:0] status_q[$];
	string      fld_names[6] = '{"relay_on", "delay_running", "emergency_stopped",
	                             "switched", "manual_event", "force_stop_event"};

	// predicted controller state and configuration
	logic             mdl_relay = 1'b0;
	logic             mdl_armed = 1'b0;
	logic             mdl_emerg = 1'b0;
	logic [CNT_W-1:0] mdl_on_ms = '0;
	logic [CNT_W-1:0] mdl_delay_ms = '0;
	logic [15:0]      cfg_delay_s = '0;
	logic [15:0]      cfg_max_on_s = '0;
	logic             cfg_boot_on = 1'b0;
	logic             ev_switched, ev_manual, ev_force;

	int  n_act[4] = '{0, 0, 0, 0};
	int  n_cfg = 0, n_trips = 0, n_restarts = 0, n_err = 0, n_out = 0, cycles = 0;
	bit  s_fire = 1'b0, cfg_fire = 1'b0;
	bit  hold_off = 1'b0, stall_on = 1'b0;
	int  gap_max = 0, gap_left = 0, burst_left = 0;
	logic [10:0] ready_pat = 11'h5B3;

	function automatic void relay_drive(logic on, logic man);
		if (man) begin
			ev_manual = 1'b1;
			mdl_armed = 1'b0;
		end
		if (mdl_relay != on) begin
			mdl_relay = on;
			ev_switched = 1'b1;
			if (on)
				mdl_emerg = 1'b0;
			mdl_on_ms = '0;
		end
	endfunction

	function automatic void relay_force_off();
		relay_drive(1'b0, 1'b1);
		mdl_emerg = 1'b1;
		ev_force = 1'b1;
	endfunction

	function automatic logic [5:0] predict_status(logic [7:0] word);
		action_t     act;
		result_t     r;
		logic        expired;
		logic [63:0] lim, load;
		act = action_t'(word[1:0]);
		ev_switched = 1'b0;
		ev_manual = 1'b0;
		ev_force = 1'b0;
		expired = 1'b0;
		case (act)
			ACT_TICK: begin
				if (mdl_relay) begin
					if (mdl_on_ms != CNT_MAX)
						mdl_on_ms = mdl_on_ms + CNT_W'(1);
					lim = 64'(cfg_max_on_s) * TICKS_PER_SECOND;
					if (cfg_max_on_s != 0 && 64'(mdl_on_ms) > lim) begin
						relay_force_off();
						n_trips++;
					end
				end
				if (mdl_armed) begin
					if (mdl_delay_ms != 0)
						mdl_delay_ms = mdl_delay_ms - CNT_W'(1);
					if (mdl_delay_ms == 0) begin
						mdl_armed = 1'b0;
						expired = 1'b1;
					end
				end
				if (expired && !mdl_relay) begin
					relay_drive(1'b1, 1'b1);
					n_restarts++;
				end
				if (!mdl_relay && !mdl_armed && cfg_delay_s != 0) begin
					load = 64'(cfg_delay_s) * TICKS_PER_SECOND;
					mdl_armed = 1'b1;
					mdl_delay_ms = (load > 64'(CNT_MAX)) ? CNT_MAX : load[CNT_W-1:0];
				end
			end
			ACT_SET: relay_drive(word[2], word[3]);
			ACT_FORCE: relay_force_off();
			default: begin
				mdl_armed = 1'b0;
				mdl_delay_ms = '0;
				mdl_emerg = 1'b0;
				mdl_on_ms = '0;
				mdl_relay = cfg_boot_on;
				ev_switched = 1'b1;
			end
		endcase
		r.relay_on = mdl_relay;
		r.delay_running = mdl_armed;
		r.emergency_stopped = mdl_emerg;
		r.switched = ev_switched;
		r.manual_event = ev_manual;
		r.force_stop_event = ev_force;
		return {r.force_stop_event, r.manual_event, r.switched, r.emergency_stopped,
			r.delay_running, r.relay_on};
	endfunction

	// monitor, predictor update and timeout
	always @(posedge clk) begin : mon
		logic [5:0] want;
		string      bad;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles, %0d status items pending", cycles,
					status_q.size());
				$display("Simulation FAILED");
				$finish;
			end else begin
				if (m_tvalid && m_tready) begin
					if (status_q.size() == 0) begin
						n_err++;
						if (n_err <= 10)
							$display("unexpected status item %b", m_tdata[5:0]);
					end else begin
						want = status_q.pop_front();
						if (m_tdata[5:0] !== want) begin
							n_err++;
							if (n_err <= 10) begin
								bad = "";
								for (int k = 0; k < 6; k++)
									if (m_tdata[k] !== want[k])
										bad = {bad, " ", fld_names[k]};
								$display("status item %0d wrong in%s: expected %b got %b",
									n_out, bad, want, m_tdata[5:0]);
							end
						end
						n_out++;
					end
				end
				cfg_fire = cfg_valid && cfg_ready;
				if (cfg_fire) begin
					case (reg_idx_t'(cfg_index))
						REG_DELAY_SECONDS: cfg_delay_s = cfg_data;
						REG_MAX_ON_SECONDS: cfg_max_on_s = cfg_data;
						REG_BOOT_ON: cfg_boot_on = cfg_data[0];
						default: ;
					endcase
					n_cfg++;
				end
				s_fire = s_tvalid && s_tready;
				if (s_fire) begin
					status_q.push_back(predict_status(s_tdata));
					n_act[s_tdata[1:0]]++;
					void'(action_q.pop_front());
				end
			end
		end
	end

	// action driver in bursts, status receiver on a rotating stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!(s_tvalid && !s_fire)) begin
				if (hold_off || action_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= action_q[0];
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = $urandom_range(0, gap_max);
					end
				end
			end
			if (stall_on) begin
				m_tready <= ready_pat[0];
				if (cycles % 64 == 0)
					ready_pat = 11'($urandom) | 11'd1;
				else
					ready_pat = {ready_pat[0], ready_pat[10:1]};
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_item(action_t a, logic sw, logic man);
		action_q.push_back({4'b0000, man, sw, a});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (action_q.size() != 0 || s_tvalid || status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_fire)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_traffic(int gmax, bit stall);
		@(posedge clk);
		gap_max = gmax;
		stall_on = stall;
	endtask

	task automatic setup(logic [15:0] dly, logic [15:0] max_on, logic boot);
		write_reg(REG_DELAY_SECONDS, dly);
		write_reg(REG_MAX_ON_SECONDS, max_on);
		write_reg(REG_BOOT_ON, {15'd0, boot});
	endtask

	// random actions, hold the sender halfway until all status items are back
	task automatic run_phase(int n, int tick_pct);
		action_t act;
		int      r;
		@(posedge clk);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < tick_pct) begin
				act = ACT_TICK;
			end else begin
				r = $urandom_range(0, 9);
				act = (r < 6) ? ACT_SET : (r < 9) ? ACT_FORCE : ACT_INIT;
			end
			push_item(act, 1'($urandom), 1'($urandom));
		end
		@(negedge clk);
		while (action_q.size() > n / 2)
			@(negedge clk);
		@(posedge clk);
		hold_off = 1'b1;
		@(negedge clk);
		while (s_tvalid || status_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
		hold_off = 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		set_traffic(2, 1'b1);
		@(posedge clk);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b1, 1'b0);
		push_item(ACT_SET, 1'b1, 1'b1);
		push_item(ACT_SET, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b0, 1'b1);
		push_item(ACT_FORCE, 1'b0, 1'b0);
		push_item(ACT_TICK, 1'b1, 1'b1);
		push_item(ACT_SET, 1'b1, 1'b1);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_FORCE, 1'b1, 1'b1);
		push_item(ACT_INIT, 1'b1, 1'b0);
		wait_idle();

		setup(16'hFFFF, 16'hFFFF, 1'b1);
		@(posedge clk);
		push_item(ACT_INIT, 1'b0, 1'b1);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_FORCE, 1'b0, 1'b0);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b1, 1'b0);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b0, 1'b1);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_INIT, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_BOOT_ON, 16'd0);
		@(posedge clk);
		push_item(ACT_INIT, 1'b0, 1'b0);
		push_item(ACT_TICK, 1'b0, 1'b0);
		wait_idle();

		set_traffic(0, 1'b0);
		setup(16'd0, 16'd0, 1'b0);
		run_phase(100, 50);
		set_traffic(3, 1'b1);
		setup(16'd1, 16'd1, 1'b1);
		run_phase(120, 90);
		set_traffic(6, 1'b1);
		setup(16'hFFFF, 16'hFFFF, 1'b1);
		run_phase(100, 50);
		for (int p = 0; p < 3; p++) begin
			set_traffic($urandom_range(0, 5), 1'($urandom));
			setup(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 1'($urandom));
			run_phase(110, 80);
		end

		// long tick run: delay expiry while already on, then watchdog trip and re-arm
		set_traffic(2, 1'b1);
		setup(16'd1, 16'd1, 1'b0);
		@(posedge clk);
		push_item(ACT_INIT, 1'b0, 1'b0);
		push_item(ACT_TICK, 1'b0, 1'b0);
		push_item(ACT_SET, 1'b1, 1'b0);
		for (int i = 0; i < 1010; i++)
			push_item(ACT_TICK, 1'($urandom), 1'($urandom));
		wait_idle();

		$display("Ran %0d ticks, %0d set commands, %0d force stops and %0d inits",
			n_act[ACT_TICK], n_act[ACT_SET], n_act[ACT_FORCE], n_act[ACT_INIT]);
		$display("%0d register writes, %0d watchdog trips, %0d delayed restarts, %0d mismatches",
			n_cfg, n_trips, n_restarts, n_err);
		if (n_err == 0 && status_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
